### hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Beat types, operation and status codes, and the command that is broadcast
// to every cell of the list.
// ----------------------------------------------------------------------------
package ple_pkg;

    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_POP_FRONT  = 4'd2;
    localparam logic [3:0] OP_POP_BACK   = 4'd3;
    localparam logic [3:0] OP_INSERT     = 4'd4;
    localparam logic [3:0] OP_DELETE     = 4'd5;
    localparam logic [3:0] OP_REPLACE    = 4'd6;
    localparam logic [3:0] OP_FIND       = 4'd7;
    localparam logic [3:0] OP_READ       = 4'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [3:0]         op;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [5:0]         found_position;
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
    } t_out_beat;

    // What every cell does in the current cycle.
    typedef enum logic [1:0] {
        ACT_HOLD,
        ACT_OPEN,
        ACT_CLOSE,
        ACT_WRITE
    } t_cell_act;

    typedef struct packed {
        t_cell_act          act;
        logic signed [31:0] value;
    } t_cell_cmd;

endpackage

### hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry, takes its neighbour's entry when the list opens or
// closes a gap, and compares its entry against the search key.
// ----------------------------------------------------------------------------
module ple_cell #(
    parameter int CAPACITY = 64,
    parameter int INDEX    = 0
) (
    input  logic                               i_clk,
    input  ple_pkg::t_cell_cmd                 i_cmd,
    input  logic [$clog2(CAPACITY)-1:0]        i_idx,
    input  logic [$clog2(CAPACITY+1)-1:0]      i_count,
    input  logic signed [31:0]                 i_left,
    input  logic signed [31:0]                 i_right,
    output logic signed [31:0]                 o_entry,
    output logic                               o_match
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic signed [31:0] r_entry;
    logic signed [31:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.act)
            ple_pkg::ACT_OPEN: begin
                if (MY_IDX > i_idx) begin
                    n_entry = i_left;
                end else if (MY_IDX == i_idx) begin
                    n_entry = i_cmd.value;
                end
            end
            ple_pkg::ACT_CLOSE: begin
                if (MY_IDX >= i_idx) begin
                    n_entry = i_right;
                end
            end
            ple_pkg::ACT_WRITE: begin
                if (MY_IDX == i_idx) begin
                    n_entry = i_cmd.value;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_cmd.value) && (CNT_W'(INDEX) < i_count);

endmodule

### hw/rtl/ple_ffs.sv
// ----------------------------------------------------------------------------
// Positional list first-match encoder
// Registers the index of the lowest set bit of the cells' match flags.
// ----------------------------------------------------------------------------
module ple_ffs #(
    parameter int CAPACITY = 64
) (
    input  logic                          i_clk,
    input  logic [CAPACITY-1:0]           i_match,
    output logic                          o_any,
    output logic [$clog2(CAPACITY)-1:0]   o_index
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [IDX_W-1:0] n_index;
    logic [IDX_W-1:0] r_index;
    logic             r_any;

    always_comb begin
        n_index = '0;
        for (int k = CAPACITY - 1; k >= 0; k--) begin
            if (i_match[k]) begin
                n_index = IDX_W'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_index <= n_index;
        r_any   <= |i_match;
    end

    assign o_any   = r_any;
    assign o_index = r_index;

endmodule

### hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded ordered list of signed 32-bit values held in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one operation per beat (push or pop at
// either end, insert, delete, replace or read at a position, or find the first
// entry equal to a key). Every input beat gives exactly one output beat with
// the status, the found position, the read value and the entry count after
// the operation.
// Sequence: an accepted beat is executed in the following cycle, in which every
// cell shifts, writes or compares in parallel. A find also passes through the
// registered first-match encoder. The result then enters the output register.
// Operations do not overlap: the block takes one operation at a time and
// accepts the next input beat only once the previous result is registered.
// A finished result waits in the output register while the receiver stalls,
// and the next input beat is already accepted in that time; its own result
// waits in the engine until the output register frees.
// Reset empties the list and drops any result in flight. Entry storage is
// not cleared; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ple_pkg::t_in_beat  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ple_pkg::t_out_beat o_out_data,
    input  logic               i_out_stall
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Common width for comparing the 6-bit position with the count.
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 7;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIND,
        S_EMIT
    } t_state;

    t_state             r_state;
    ple_pkg::t_in_beat  r_in;
    ple_pkg::t_out_beat r_res;
    ple_pkg::t_out_beat r_out;
    logic               r_out_valid;
    logic [CNT_W-1:0]   r_count;

    // Decoded execution of the held operation.
    ple_pkg::t_cell_act n_act;
    logic [IDX_W-1:0]   n_idx;
    logic [1:0]         n_status;
    logic [CNT_W-1:0]   n_count;
    logic signed [31:0] n_read;

    ple_pkg::t_cell_cmd w_cmd;
    logic signed [31:0] w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_match;
    logic               w_any;
    logic [IDX_W-1:0]   w_found;

    logic               w_full;
    logic               w_empty;
    logic               w_in_range;
    logic [IDX_W-1:0]   w_pos_idx;
    logic               w_out_free;

    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);
    assign w_in_range = (CMP_W'(r_in.position) < CMP_W'(r_count));
    assign w_pos_idx  = IDX_W'(r_in.position);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_act    = ple_pkg::ACT_HOLD;
        n_idx    = '0;
        n_status = ple_pkg::ST_OK;
        n_count  = r_count;
        n_read   = '0;
        case (r_in.op)
            ple_pkg::OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    n_act   = ple_pkg::ACT_OPEN;
                    n_count = r_count + 1'b1;
                end
            end
            ple_pkg::OP_PUSH_BACK: begin
                if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    n_act   = ple_pkg::ACT_OPEN;
                    n_idx   = IDX_W'(r_count);
                    n_count = r_count + 1'b1;
                end
            end
            ple_pkg::OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_act   = ple_pkg::ACT_CLOSE;
                    n_count = r_count - 1'b1;
                end
            end
            ple_pkg::OP_POP_BACK: begin
                if (w_empty) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_act   = ple_pkg::ACT_CLOSE;
                    n_idx   = IDX_W'(r_count - 1'b1);
                    n_count = r_count - 1'b1;
                end
            end
            ple_pkg::OP_INSERT: begin
                // The position is checked before the list is checked for room.
                if (!w_in_range) begin
                    n_status = ple_pkg::ST_RANGE;
                end else if (w_full) begin
                    n_status = ple_pkg::ST_FULL;
                end else begin
                    n_act   = ple_pkg::ACT_OPEN;
                    n_idx   = w_pos_idx;
                    n_count = r_count + 1'b1;
                end
            end
            ple_pkg::OP_DELETE: begin
                if (!w_in_range) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_act   = ple_pkg::ACT_CLOSE;
                    n_idx   = w_pos_idx;
                    n_count = r_count - 1'b1;
                end
            end
            ple_pkg::OP_REPLACE: begin
                if (!w_in_range) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_act = ple_pkg::ACT_WRITE;
                    n_idx = w_pos_idx;
                end
            end
            ple_pkg::OP_FIND: begin
                // Resolved in the find state from the registered first-match encoder.
                n_status = ple_pkg::ST_MISSING;
            end
            ple_pkg::OP_READ: begin
                if (!w_in_range) begin
                    n_status = ple_pkg::ST_RANGE;
                end else begin
                    n_read = w_entry[w_pos_idx];
                end
            end
            default: begin
                n_status = ple_pkg::ST_RANGE;
            end
        endcase
    end

    // Cells only act during the execute cycle; at other times they still
    // compare, but only the find state uses the encoder's registered result.
    assign w_cmd.act   = (r_state == S_EXEC) ? n_act : ple_pkg::ACT_HOLD;
    assign w_cmd.value = r_in.value;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_inner_left
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_inner_right
            assign w_right = w_entry[g+1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_idx   (n_idx),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_match (w_match[g])
        );
    end

    ple_ffs #(
        .CAPACITY (CAPACITY)
    ) u_ffs (
        .i_clk   (i_clk),
        .i_match (w_match),
        .o_any   (w_any),
        .o_index (w_found)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            // In the emit state the output register is reloaded instead.
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in    <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_count                <= n_count;
                    r_res.status           <= n_status;
                    r_res.found_position   <= '0;
                    r_res.read_value       <= n_read;
                    r_res.entry_count      <= 7'(n_count);
                    r_state <= (r_in.op == ple_pkg::OP_FIND) ? S_FIND : S_EMIT;
                end
                S_FIND: begin
                    if (w_any) begin
                        r_res.status         <= ple_pkg::ST_OK;
                        r_res.found_position <= 6'(w_found);
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### hw/rtl/ple_chk.sv
// ----------------------------------------------------------------------------
// Positional list engine checker
// Port-level assertions on the input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module ple_chk #(
    parameter int CAPACITY = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input ple_pkg::t_out_beat o_out_data,
    input logic               i_out_stall
);

    // A result is never dropped while the receiver stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped under stall");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat present after reset");

    // A full status is only reported with the list at capacity.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ple_pkg::ST_FULL)
        |-> (o_out_data.entry_count == 7'(CAPACITY)))
        else $error("full status with list below capacity");

    // Failed operations carry neither a read value nor a found position.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != ple_pkg::ST_OK)
        |-> (o_out_data.read_value == '0) && (o_out_data.found_position == '0))
        else $error("failed operation returned data");

    // An accepted operation stalls the input in the next cycle, so no second operation enters while it is in flight.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while an operation is in flight");

endmodule

bind positional_list_engine ple_chk #(
    .CAPACITY (CAPACITY)
) u_ple_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
